// ===== rtl/bmmd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmmd_pkg
// Shared widths, codes and controller/datapath interface types for the
// block mean / min-max decimator.
// ----------------------------------------------------------------------------
package bmmd_pkg;

   localparam int SAMPLE_BITS = 16;
   localparam int MAX_BLOCK   = 4096;
   localparam int LEN_BITS    = 13;   // block_length register width
   localparam int POS_BITS    = 12;   // holds 0 .. MAX_BLOCK-1
   localparam int SUM_BITS    = 28;   // MAX_BLOCK * full-scale sample, signed
   localparam int DIV_STEPS   = SUM_BITS;
   localparam int CNT_BITS    = 5;
   localparam int IDX_BITS    = 2;

   // register indexes
   localparam logic [IDX_BITS-1:0] REG_DIGEST_MODE  = 2'd0;
   localparam logic [IDX_BITS-1:0] REG_BLOCK_LENGTH = 2'd1;

   // digest modes
   localparam logic MODE_MEAN   = 1'b0;
   localparam logic MODE_MINMAX = 1'b1;

   // controller -> datapath
   typedef struct packed {
      logic take;       // sample beat accepted
      logic div_start;  // load divider with the finished block sum
      logic div_step;   // one quotient bit
      logic load_out;   // move result into output register
   } bmmd_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic block_done; // current sample completes the block
      logic div_last;   // this step produces the final quotient bit
      logic out_free;   // output register can take a result this cycle
      logic mode;       // digest mode in force
   } bmmd_sts_type;

endpackage

// ===== rtl/block_mean_minmax_decimator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_mean_minmax_decimator
// Cuts a signed sample stream into blocks of block_length samples and emits
// one summary per finished block: the truncated mean, or min/max/first/last.
// ----------------------------------------------------------------------------
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  req     | req_valid/req_ready, req_sample         | in
//  rsp     | rsp_valid/rsp_ready, rsp_mean_or_min,   | out
//          | rsp_block_max, rsp_block_first,         |
//          | rsp_block_last                          |
//  csr     | csr_valid/csr_ready, csr_index,         | in
//          | csr_data (0 = digest_mode,              |
//          | 1 = block_length, others ignored)       |
//
// A sample that does not end a block leaves intake open; one that ends it
// closes intake and, in mean mode, starts 28 divider steps (one quotient
// bit each over |sum|) before the hand-off; in min/max mode it goes
// straight to the hand-off, which waits while the output register holds
// an untaken beat; otherwise samples flow in while a result waits there.
// Reset (synchronous): mode = mean, block_length = 64, block position = 0.
// ----------------------------------------------------------------------------
module block_mean_minmax_decimator (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic signed [bmmd_pkg::SAMPLE_BITS-1:0] req_sample,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic signed [bmmd_pkg::SAMPLE_BITS-1:0] rsp_mean_or_min,
   output logic signed [bmmd_pkg::SAMPLE_BITS-1:0] rsp_block_max,
   output logic signed [bmmd_pkg::SAMPLE_BITS-1:0] rsp_block_first,
   output logic signed [bmmd_pkg::SAMPLE_BITS-1:0] rsp_block_last,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [bmmd_pkg::IDX_BITS-1:0]           csr_index,
   input  logic [bmmd_pkg::LEN_BITS-1:0]           csr_data
);

   bmmd_pkg::bmmd_cmd_type cmd;
   bmmd_pkg::bmmd_sts_type sts;

   // config writes never stall
   assign csr_ready = 1'b1;

   // sequencer: intake -> (divide) -> hand-off
   bmmd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // accumulators, divider, output register
   bmmd_datapath u_dp (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .req_sample      (req_sample),
      .rsp_ready       (rsp_ready),
      .rsp_valid       (rsp_valid),
      .rsp_mean_or_min (rsp_mean_or_min),
      .rsp_block_max   (rsp_block_max),
      .rsp_block_first (rsp_block_first),
      .rsp_block_last  (rsp_block_last),
      .cmd             (cmd),
      .sts             (sts)
   );

endmodule

// ===== rtl/bmmd_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmmd_ctrl
// Sequencer: sample intake, mean division, result hand-off.
// ----------------------------------------------------------------------------
module bmmd_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  bmmd_pkg::bmmd_sts_type sts,
   output bmmd_pkg::bmmd_cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_ACCEPT = 3'b001,
      ST_DIVIDE = 3'b010,
      ST_PUSH   = 3'b100
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_ACCEPT: begin
            cmd.take = req_valid;
            if (req_valid && sts.block_done) begin
               if (sts.mode == bmmd_pkg::MODE_MINMAX) begin
                  state_in = ST_PUSH;
               end else begin
                  cmd.div_start = 1'b1;
                  state_in      = ST_DIVIDE;
               end
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: begin
            if (sts.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_ACCEPT;
            end
         end
         default: begin
            state_in = ST_ACCEPT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_ACCEPT;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == ST_ACCEPT);

endmodule

// ===== rtl/bmmd_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmmd_datapath
// Config registers, block accumulators, radix-2 divider, output register.
// ----------------------------------------------------------------------------
module bmmd_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   input  logic [bmmd_pkg::IDX_BITS-1:0]        csr_index,
   input  logic [bmmd_pkg::LEN_BITS-1:0]        csr_data,
   input  logic signed [bmmd_pkg::SAMPLE_BITS-1:0] req_sample,
   input  logic                                 rsp_ready,
   output logic                                 rsp_valid,
   output logic signed [bmmd_pkg::SAMPLE_BITS-1:0] rsp_mean_or_min,
   output logic signed [bmmd_pkg::SAMPLE_BITS-1:0] rsp_block_max,
   output logic signed [bmmd_pkg::SAMPLE_BITS-1:0] rsp_block_first,
   output logic signed [bmmd_pkg::SAMPLE_BITS-1:0] rsp_block_last,
   input  bmmd_pkg::bmmd_cmd_type               cmd,
   output bmmd_pkg::bmmd_sts_type               sts
);

   localparam int SB = bmmd_pkg::SAMPLE_BITS;
   localparam int LB = bmmd_pkg::LEN_BITS;
   localparam int PB = bmmd_pkg::POS_BITS;
   localparam int WB = bmmd_pkg::SUM_BITS;
   localparam int CB = bmmd_pkg::CNT_BITS;

   // config
   logic          mode_ff, mode_in;
   logic [LB-1:0] blen_ff, blen_in;
   logic [LB-1:0] len_eff;

   always_comb begin
      mode_in = mode_ff;
      blen_in = blen_ff;
      if (csr_valid) begin
         unique case (csr_index)
            bmmd_pkg::REG_DIGEST_MODE:  mode_in = csr_data[0];
            bmmd_pkg::REG_BLOCK_LENGTH: blen_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= bmmd_pkg::MODE_MEAN;
         blen_ff <= LB'(64);
      end else begin
         mode_ff <= mode_in;
         blen_ff <= blen_in;
      end
   end

   always_comb begin
      if (blen_ff == '0) begin
         len_eff = LB'(1);
      end else if (blen_ff > LB'(bmmd_pkg::MAX_BLOCK)) begin
         len_eff = LB'(bmmd_pkg::MAX_BLOCK);
      end else begin
         len_eff = blen_ff;
      end
   end

   // block accumulators
   logic [PB-1:0]        pos_ff, pos_in;
   logic [LB-1:0]        pos_next;
   logic signed [WB-1:0] sum_ff, sum_in;
   logic signed [SB-1:0] min_ff, min_in, max_ff, max_in;
   logic signed [SB-1:0] first_ff, first_in, last_ff, last_in;
   logic signed [WB-1:0] sample_x;
   logic                 starting;
   logic                 block_done;

   assign pos_next   = {1'b0, pos_ff} + LB'(1);
   assign block_done = (pos_next >= len_eff);
   assign starting   = (pos_ff == '0);
   assign sample_x   = WB'(req_sample);

   always_comb begin
      pos_in   = pos_ff;
      sum_in   = sum_ff;
      min_in   = min_ff;
      max_in   = max_ff;
      first_in = first_ff;
      last_in  = last_ff;
      if (cmd.take) begin
         last_in = req_sample;
         pos_in  = block_done ? '0 : pos_next[PB-1:0];
         if (starting) begin
            sum_in   = sample_x;
            min_in   = req_sample;
            max_in   = req_sample;
            first_in = req_sample;
         end else begin
            sum_in = sum_ff + sample_x;
            if (req_sample < min_ff) min_in = req_sample;
            if (req_sample > max_ff) max_in = req_sample;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         sum_ff   <= '0;
         min_ff   <= '0;
         max_ff   <= '0;
         first_ff <= '0;
         last_ff  <= '0;
      end else begin
         pos_ff   <= pos_in;
         sum_ff   <= sum_in;
         min_ff   <= min_in;
         max_ff   <= max_in;
         first_ff <= first_in;
         last_ff  <= last_in;
      end
   end

   // restoring divider on |sum|, one quotient bit per step;
   // quotient shifts into dvd_ff as dividend bits shift out
   logic [WB-1:0] dvd_ff, dvd_in;
   logic [LB-1:0] rem_ff, rem_in;
   logic          neg_ff, neg_in;
   logic [CB-1:0] cnt_ff, cnt_in;
   logic [LB:0]   rem_sh;
   logic          fits;
   logic [LB-1:0] rem_sub;
   logic [SB-1:0] quot;

   assign rem_sh  = {rem_ff, dvd_ff[WB-1]};
   assign fits    = (rem_sh >= {1'b0, len_eff});
   // rem_sh < 2 * len_eff, so the difference fits in LB bits when it fits
   assign rem_sub = rem_sh[LB-1:0] - len_eff;

   always_comb begin
      dvd_in = dvd_ff;
      rem_in = rem_ff;
      neg_in = neg_ff;
      cnt_in = cnt_ff;
      if (cmd.div_start) begin
         neg_in = sum_in[WB-1];
         dvd_in = sum_in[WB-1] ? (~sum_in + WB'(1)) : sum_in;
         rem_in = '0;
         cnt_in = '0;
      end else if (cmd.div_step) begin
         dvd_in = {dvd_ff[WB-2:0], fits};
         rem_in = fits ? rem_sub : rem_sh[LB-1:0];
         cnt_in = cnt_ff + CB'(1);
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      neg_ff <= neg_in;
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   // result field keeps the low SB bits of the signed quotient
   assign quot = neg_ff ? (~dvd_ff[SB-1:0] + SB'(1)) : dvd_ff[SB-1:0];

   // output register
   logic          out_valid_ff, out_valid_in;
   logic [SB-1:0] o_min_ff, o_min_in, o_max_ff, o_max_in;
   logic [SB-1:0] o_first_ff, o_first_in, o_last_ff, o_last_in;

   always_comb begin
      out_valid_in = out_valid_ff && !rsp_ready;
      o_min_in     = o_min_ff;
      o_max_in     = o_max_ff;
      o_first_in   = o_first_ff;
      o_last_in    = o_last_ff;
      if (cmd.load_out) begin
         out_valid_in = 1'b1;
         if (mode_ff == bmmd_pkg::MODE_MINMAX) begin
            o_min_in   = min_ff;
            o_max_in   = max_ff;
            o_first_in = first_ff;
            o_last_in  = last_ff;
         end else begin
            o_min_in   = quot;
            o_max_in   = '0;
            o_first_in = '0;
            o_last_in  = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      o_min_ff   <= o_min_in;
      o_max_ff   <= o_max_in;
      o_first_ff <= o_first_in;
      o_last_ff  <= o_last_in;
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_mean_or_min = o_min_ff;
   assign rsp_block_max   = o_max_ff;
   assign rsp_block_first = o_first_ff;
   assign rsp_block_last  = o_last_ff;

   assign sts.block_done = block_done;
   assign sts.div_last   = (cnt_ff == CB'(bmmd_pkg::DIV_STEPS - 1));
   assign sts.out_free   = !out_valid_ff || rsp_ready;
   assign sts.mode       = mode_ff;

endmodule

// ===== rtl/bmmd_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmmd_checker
// Port-level checks for the decimator, bound to the top level.
// ----------------------------------------------------------------------------
module bmmd_checker (
   input logic                                    clock,
   input logic                                    reset,
   input logic                                    req_valid,
   input logic                                    req_ready,
   input logic                                    rsp_valid,
   input logic                                    rsp_ready,
   input logic signed [bmmd_pkg::SAMPLE_BITS-1:0] rsp_mean_or_min,
   input logic signed [bmmd_pkg::SAMPLE_BITS-1:0] rsp_block_max,
   input logic signed [bmmd_pkg::SAMPLE_BITS-1:0] rsp_block_first,
   input logic signed [bmmd_pkg::SAMPLE_BITS-1:0] rsp_block_last
);

   // no result survives reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // intake closes only on an accepted sample beat
   a_ready_drop: assert property (@(posedge clock) disable iff (reset)
      $fell(req_ready) |-> $past(req_valid && req_ready))
      else $error("req_ready dropped without a sample beat");

   // a result appears only out of the hand-off, while intake is closed
   a_rsp_origin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result appeared while intake open");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_mean_or_min)
         && $stable(rsp_block_max) && $stable(rsp_block_first)
         && $stable(rsp_block_last))
      else $error("stalled result changed");

endmodule

bind block_mean_minmax_decimator bmmd_checker u_bmmd_checker (.*);

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for block_mean_minmax_decimator. A short scripted run
// covers reset values, field extremes, zero and oversize block lengths,
// truncation of negative means, ignored register indexes, and length or
// mode changes in the middle of a block. A long randomized run with random
// idle cycles on both channels follows. Every result beat is compared field
// by field with a digest predicted inside the bench.
// ----------------------------------------------------------------------------
module tb_top;

   // Far above the slowest legal run: about 2k samples, each with the
   // longest sender gap and its own digest paying a full divide plus the
   // longest receiver stall, and up to three quiet-time register writes per
   // random phase, each with its settle wait.
   localparam int unsigned CYCLE_LIMIT    = 3_000_000;
   localparam int          SETTLE_CYCLES  = 40;    // covers the mean path with its divide
   localparam int          RANDOM_SAMPLES = 1350;
   localparam int          HOLD_CYCLES    = 400;   // long rsp back-pressure stretch

   // indexes that the block decodes as nothing
   localparam logic [bmmd_pkg::IDX_BITS-1:0] REG_SPARE_2 = 2'd2;
   localparam logic [bmmd_pkg::IDX_BITS-1:0] REG_SPARE_3 = 2'd3;

   typedef logic signed [bmmd_pkg::SAMPLE_BITS-1:0] sample_type;

   localparam sample_type SAMPLE_MIN = sample_type'(16'h8000);
   localparam sample_type SAMPLE_MAX = sample_type'(16'h7fff);

   typedef struct packed {
      sample_type mean_or_min;
      sample_type block_max;
      sample_type block_first;
      sample_type block_last;
   } digest_type;

   typedef enum logic { ROW_WRITE, ROW_SAMPLE } row_kind_type;

   // one line of the scripted run: a register write, or a sample sent
   // reps times; want is compared on the last repeat when chk is set
   typedef struct {
      row_kind_type                  kind;
      logic [bmmd_pkg::IDX_BITS-1:0] idx;
      logic [bmmd_pkg::LEN_BITS-1:0] data;
      sample_type                    value;
      int unsigned                   reps;
      bit                            chk;
      digest_type                    want;
   } script_row_type;

   // ---------------------------------------------------------------------
   // DUT ports; the bench-driven inputs are known from time zero
   // ---------------------------------------------------------------------
   logic                          clock      = 1'b0;
   logic                          reset      = 1'b1;
   logic                          req_valid  = 1'b0;
   logic                          req_ready;
   sample_type                    req_sample = '0;
   logic                          rsp_valid;
   logic                          rsp_ready  = 1'b0;
   sample_type                    rsp_mean_or_min;
   sample_type                    rsp_block_max;
   sample_type                    rsp_block_first;
   sample_type                    rsp_block_last;
   logic                          csr_valid  = 1'b0;
   logic                          csr_ready;
   logic [bmmd_pkg::IDX_BITS-1:0] csr_index  = '0;
   logic [bmmd_pkg::LEN_BITS-1:0] csr_data   = '0;

   // ---------------------------------------------------------------------
   // Bench state
   // ---------------------------------------------------------------------
   script_row_type script[$];
   digest_type     pending_digests[$];   // digests predicted, beat not yet seen

   int unsigned cycle_cnt   = 0;
   int unsigned errs        = 0;
   int unsigned n_samples   = 0;
   int unsigned n_writes    = 0;
   int unsigned n_digests   = 0;
   bit          req_eager   = 1'b0;   // sender runs with no gaps
   bit          rsp_eager   = 1'b0;   // receiver runs with no stalls
   logic        pressure_go = 1'b0;
   logic        hold_rsp    = 1'b0;

   // Predictor copy of the block: registers as written, plus the running
   // summary of the block in progress. Values match the block after reset.
   logic                                 cfg_mode  = bmmd_pkg::MODE_MEAN;
   logic [bmmd_pkg::LEN_BITS-1:0]        cfg_len   = 13'd64;
   int unsigned                          blk_pos   = 0;
   logic signed [bmmd_pkg::SUM_BITS-1:0] blk_sum   = '0;
   sample_type                           blk_min   = '0;
   sample_type                           blk_max   = '0;
   sample_type                           blk_first = '0;

   block_mean_minmax_decimator i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_sample      (req_sample),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_mean_or_min (rsp_mean_or_min),
      .rsp_block_max   (rsp_block_max),
      .rsp_block_first (rsp_block_first),
      .rsp_block_last  (rsp_block_last),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   // 2 ns period
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Digest predictor: folds one accepted sample into the running block.
   // Returns 1 with the digest when this sample closes the block.
   // Length 0 counts as 1, anything above MAX_BLOCK as MAX_BLOCK; a count
   // already past a freshly shortened length closes on the next sample.
   // ---------------------------------------------------------------------
   function automatic bit fold_sample(input sample_type s, output digest_type d);
      int unsigned                          len;
      logic signed [bmmd_pkg::SUM_BITS-1:0] quo;
      d = '0;
      if (cfg_len == '0)
         len = 1;
      else if (cfg_len > bmmd_pkg::MAX_BLOCK)
         len = bmmd_pkg::MAX_BLOCK;
      else
         len = 32'(cfg_len);

      // both summaries always run; the mode at block end picks one
      if (blk_pos == 0) begin
         blk_sum   = bmmd_pkg::SUM_BITS'(s);
         blk_min   = s;
         blk_max   = s;
         blk_first = s;
      end else begin
         blk_sum = blk_sum + bmmd_pkg::SUM_BITS'(s);
         if (s < blk_min) blk_min = s;
         if (s > blk_max) blk_max = s;
      end
      blk_pos++;
      if (blk_pos < len)
         return 1'b0;

      blk_pos = 0;
      if (cfg_mode == bmmd_pkg::MODE_MEAN) begin
         // signed divide truncates toward zero
         quo = blk_sum / $signed(bmmd_pkg::SUM_BITS'(len));
         d.mean_or_min = quo[bmmd_pkg::SAMPLE_BITS-1:0];
      end else begin
         d = '{blk_min, blk_max, blk_first, s};
      end
      return 1'b1;
   endfunction

   // ---------------------------------------------------------------------
   // Script rows
   // ---------------------------------------------------------------------
   function automatic void wr(input logic [bmmd_pkg::IDX_BITS-1:0] idx,
                              input logic [bmmd_pkg::LEN_BITS-1:0] data);
      script_row_type row;
      row.kind  = ROW_WRITE;
      row.idx   = idx;
      row.data  = data;
      row.value = '0;
      row.reps  = 0;
      row.chk   = 1'b0;
      row.want  = '0;
      script.push_back(row);
   endfunction

   function automatic void smp(input sample_type v, input int unsigned reps);
      script_row_type row;
      row.kind  = ROW_SAMPLE;
      row.idx   = '0;
      row.data  = '0;
      row.value = v;
      row.reps  = reps;
      row.chk   = 1'b0;
      row.want  = '0;
      script.push_back(row);
   endfunction

   function automatic void smp_chk(input sample_type v, input int unsigned reps,
                                   input sample_type m, input sample_type mx,
                                   input sample_type f, input sample_type l);
      script_row_type row;
      row.kind  = ROW_SAMPLE;
      row.idx   = '0;
      row.data  = '0;
      row.value = v;
      row.reps  = reps;
      row.chk   = 1'b1;
      row.want  = '{m, mx, f, l};
      script.push_back(row);
   endfunction

   // ---------------------------------------------------------------------
   // req side: optional idle gap, then hold valid until the beat is taken.
   // Returns at the accepting edge, so the caller may keep valid high for
   // the next beat or drop it, with one assignment in that step.
   // ---------------------------------------------------------------------
   task automatic send_sample(input sample_type s);
      int unsigned gap;
      gap = req_eager ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= s;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      n_samples++;
   endtask

   // Register write, only with the block quiet: every predicted digest has
   // arrived and a divide that may still be in flight has had time to end.
   task automatic csr_write(input logic [bmmd_pkg::IDX_BITS-1:0] idx,
                            input logic [bmmd_pkg::LEN_BITS-1:0] data);
      req_valid <= 1'b0;
      while (pending_digests.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         bmmd_pkg::REG_DIGEST_MODE:  cfg_mode = data[0];
         bmmd_pkg::REG_BLOCK_LENGTH: cfg_len  = data;
         default: ;        // unknown index: no effect
      endcase
      csr_valid <= 1'b0;
      n_writes++;
   endtask

   // ---------------------------------------------------------------------
   // rsp side: per beat, an optional random stall, none while eager. The long
   // hold-off below overrides and keeps ready low.
   // ---------------------------------------------------------------------
   initial begin : rsp_side
      int unsigned n;
      while (reset) @(posedge clock);
      forever begin
         if ($urandom_range(0, 7) == 0) rsp_eager = !rsp_eager;
         n = rsp_eager ? 0 : $urandom_range(0, 6);
         if (n > 0 || hold_rsp) begin
            rsp_ready <= 1'b0;
            repeat (n) @(posedge clock);
            while (hold_rsp) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   // Long back-pressure: the output register fills and req_ready drops
   // while the sender keeps a beat offered.
   initial begin : hold_off
      wait (pressure_go);
      hold_rsp <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   // ---------------------------------------------------------------------
   // Result checker
   // ---------------------------------------------------------------------
   function automatic void check_field(input string name, input sample_type want,
                                       input sample_type got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         errs++;
      end
   endfunction

   always @(posedge clock) begin
      digest_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_digests.size() == 0) begin
            $error("digest beat with none pending: %0d %0d %0d %0d",
                   rsp_mean_or_min, rsp_block_max, rsp_block_first, rsp_block_last);
            errs++;
         end else begin
            want = pending_digests.pop_front();
            check_field("mean_or_min", want.mean_or_min, rsp_mean_or_min);
            check_field("block_max", want.block_max, rsp_block_max);
            check_field("block_first", want.block_first, rsp_block_first);
            check_field("block_last", want.block_last, rsp_block_last);
            n_digests++;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt == CYCLE_LIMIT) begin
         $error("timeout after %0d cycles, %0d digests pending",
                cycle_cnt, pending_digests.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   initial begin : stimulus
      int unsigned r, i, cnt, rnd_done;
      sample_type  s;
      digest_type  d;
      bit          has;
      bit          pressure_done;

      // Scripted part. Expected digests typed in below are the ones that
      // follow directly from the sample values.

      // reset values: mean mode, 64-sample blocks
      smp_chk(SAMPLE_MAX, 64, SAMPLE_MAX, 0, 0, 0);
      // one-sample blocks, mean is the sample itself
      wr(bmmd_pkg::REG_BLOCK_LENGTH, 13'd1);
      smp_chk(SAMPLE_MIN, 1, SAMPLE_MIN, 0, 0, 0);
      smp_chk(-16'sd1, 1, -16'sd1, 0, 0, 0);
      wr(bmmd_pkg::REG_DIGEST_MODE, bmmd_pkg::LEN_BITS'(bmmd_pkg::MODE_MINMAX));
      smp_chk(SAMPLE_MIN, 1, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN);
      smp_chk(SAMPLE_MAX, 1, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX);
      // zero length acts as one
      wr(bmmd_pkg::REG_BLOCK_LENGTH, '0);
      smp_chk(16'sd5, 1, 16'sd5, 16'sd5, 16'sd5, 16'sd5);
      // min/max/first/last over three samples
      wr(bmmd_pkg::REG_BLOCK_LENGTH, 13'd3);
      smp(16'sd7, 1);
      smp(SAMPLE_MIN, 1);
      smp_chk(SAMPLE_MAX, 1, SAMPLE_MIN, SAMPLE_MAX, 16'sd7, SAMPLE_MAX);
      // only bit 0 of a mode write counts: back to mean
      wr(bmmd_pkg::REG_DIGEST_MODE, 13'h1ffe);
      wr(bmmd_pkg::REG_BLOCK_LENGTH, 13'd2);
      // negative means truncate toward zero
      smp(-16'sd1, 1);
      smp_chk(-16'sd2, 1, -16'sd1, 0, 0, 0);
      smp(SAMPLE_MIN, 1);
      smp_chk(-16'sd32767, 1, -16'sd32767, 0, 0, 0);
      // writes to unknown indexes change nothing
      wr(REG_SPARE_2, 13'h1fff);
      wr(REG_SPARE_3, '0);
      smp(16'sd3, 1);
      smp_chk(16'sd4, 1, 16'sd3, 0, 0, 0);
      // length cut below the count mid-block: next sample closes it
      wr(bmmd_pkg::REG_BLOCK_LENGTH, 13'd4);
      smp(16'sd10, 1);
      smp(16'sd20, 1);
      smp(16'sd30, 1);
      wr(bmmd_pkg::REG_BLOCK_LENGTH, 13'd2);
      smp_chk(16'sd40, 1, 16'sd50, 0, 0, 0);
      // mode switched mid-block: the mode at block end decides
      wr(bmmd_pkg::REG_BLOCK_LENGTH, 13'd3);
      smp(16'sd1, 1);
      smp(16'sd2, 1);
      wr(bmmd_pkg::REG_DIGEST_MODE, bmmd_pkg::LEN_BITS'(bmmd_pkg::MODE_MINMAX));
      smp_chk(16'sd9, 1, 16'sd1, 16'sd9, 16'sd1, 16'sd9);
      // oversize length: 200 samples leave the block open, then a cut
      // to 2 closes it on the next sample
      wr(bmmd_pkg::REG_DIGEST_MODE, bmmd_pkg::LEN_BITS'(bmmd_pkg::MODE_MEAN));
      wr(bmmd_pkg::REG_BLOCK_LENGTH, 13'h1fff);
      smp(16'sd100, 200);
      wr(bmmd_pkg::REG_BLOCK_LENGTH, 13'd2);
      smp(16'sd100, 1);
      // full-scale negative block
      wr(bmmd_pkg::REG_BLOCK_LENGTH, 13'd64);
      smp_chk(SAMPLE_MIN, 64, SAMPLE_MIN, 0, 0, 0);

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (script[k]) begin
         if (script[k].kind == ROW_WRITE) begin
            csr_write(script[k].idx, script[k].data);
         end else begin
            for (r = 1; r <= script[k].reps; r++) begin
               send_sample(script[k].value);
               has = fold_sample(script[k].value, d);
               if (script[k].chk && r == script[k].reps)
                  pending_digests.push_back(script[k].want);
               else if (has)
                  pending_digests.push_back(d);
            end
         end
      end

      // Randomized part, in phases: optional register writes while quiet,
      // then a burst of samples that may stop mid-block.
      rnd_done      = 0;
      pressure_done = 1'b0;
      while (rnd_done < RANDOM_SAMPLES) begin
         if (!pressure_done && rnd_done >= RANDOM_SAMPLES / 2) begin
            // one digest per beat, no gaps, rsp held off for a long while
            csr_write(bmmd_pkg::REG_BLOCK_LENGTH, 13'd1);
            pressure_go   <= 1'b1;
            req_eager      = 1'b1;
            cnt            = 40;
            pressure_done  = 1'b1;
         end else begin
            if ($urandom_range(0, 1) == 0)
               csr_write(bmmd_pkg::REG_DIGEST_MODE,
                         bmmd_pkg::LEN_BITS'($urandom_range(0, 8191)));
            if ($urandom_range(0, 3) != 0) begin
               case ($urandom_range(0, 9))
                  0:       csr_write(bmmd_pkg::REG_BLOCK_LENGTH, '0);
                  1:       csr_write(bmmd_pkg::REG_BLOCK_LENGTH,
                                     bmmd_pkg::LEN_BITS'($urandom_range(
                                        bmmd_pkg::MAX_BLOCK, 8191)));
                  2:       csr_write(bmmd_pkg::REG_BLOCK_LENGTH,
                                     bmmd_pkg::LEN_BITS'($urandom_range(9, 40)));
                  default: csr_write(bmmd_pkg::REG_BLOCK_LENGTH,
                                     bmmd_pkg::LEN_BITS'($urandom_range(1, 8)));
               endcase
            end
            if ($urandom_range(0, 9) == 0)
               csr_write(($urandom_range(0, 1) == 0) ? REG_SPARE_2 : REG_SPARE_3,
                         bmmd_pkg::LEN_BITS'($urandom()));
            req_eager = ($urandom_range(0, 3) == 0);
            // long lengths mostly leave a partial block for the next phase
            cnt = (cfg_len > 40) ? $urandom_range(1, 200) : $urandom_range(1, 60);
         end

         for (i = 0; i < cnt; i++) begin
            case ($urandom_range(0, 9))
               0:       s = SAMPLE_MIN;
               1:       s = SAMPLE_MAX;
               2:       s = '0;
               3:       s = -16'sd1;
               4, 5:    s = sample_type'($urandom_range(0, 64)) - 16'sd32;
               default: s = sample_type'($urandom());
            endcase
            send_sample(s);
            if (fold_sample(s, d)) pending_digests.push_back(d);
            rnd_done++;
         end
      end

      // drain: every predicted digest seen, then room for a late stray beat
      req_valid <= 1'b0;
      while (pending_digests.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("covered %0d samples, %0d register writes, %0d digests compared",
               n_samples, n_writes, n_digests);
      $display("both modes, lengths 0..oversize, mid-block changes, long rsp hold-off");
      if (errs == 0 && pending_digests.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/bmmd_pkg.sv
rtl/bmmd_ctrl.sv
rtl/bmmd_datapath.sv
rtl/block_mean_minmax_decimator.sv
rtl/bmmd_checker.sv
verif/tb_top.sv
